### sv/sfmx_pkg.sv
// ----------------------------------------------------------------------------
// sfmx_pkg
// shared constants, state codes and the exp table for the softmax top-k block
// ----------------------------------------------------------------------------
package sfmx_pkg;

  localparam int unsigned MaxClasses = 1024;
  localparam int unsigned MaxTop     = 16;
  localparam int unsigned AddrW      = $clog2(MaxClasses);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned LogitW     = 16;
  localparam int unsigned ProbW      = 17;
  localparam int unsigned SumW       = 28;
  localparam int unsigned TopKW      = 5;
  localparam int unsigned RankW      = 4;
  localparam logic [16:0] Log2eQ16   = 17'd94548;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_CHECK  = 12'b0000_0000_0010,
    ST_EX_RD  = 12'b0000_0000_0100,
    ST_EX_MUL = 12'b0000_0000_1000,
    ST_EX_INT = 12'b0000_0001_0000,
    ST_EX_WR  = 12'b0000_0010_0000,
    ST_DV_RD  = 12'b0000_0100_0000,
    ST_DV_LD  = 12'b0000_1000_0000,
    ST_DV_IT  = 12'b0001_0000_0000,
    ST_DV_WR  = 12'b0010_0000_0000,
    ST_RK_RUN = 12'b0100_0000_0000,
    ST_RK_EMT = 12'b1000_0000_0000
  } state_e;

  // 2^(-j/16) in q16
  function automatic logic [16:0] exp_tab(input logic [4:0] j);
    logic [16:0] v;
    unique case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

### sv/sfmx_ram.sv
// ----------------------------------------------------------------------------
// sfmx_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sfmx_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/softmax_top_k_select_top.sv
// after the last logit of n classes: an exp pass over the n classes, a
// division pass (17-step divider), then top_k ranking passes over the
// store; logits load one per cycle while idle
// rate is set by the per-class exp and divider passes and the ranking sweeps over the store
// reset: async active low, clears the sample state and sets top_k to 1;
// the logit and probability memories are not cleared
// ----------------------------------------------------------------------------
// softmax_top_k_select_top
// stores one sample's logits, computes softmax probabilities, emits top-k
// ----------------------------------------------------------------------------
module softmax_top_k_select_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // logit
  input  logic        s_axis_tlast_i,  // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // class index, logit_out, probability, rank
  output logic        m_axis_tuser_o,  // error
  output logic        m_axis_tlast_o,  // last_out
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned AW = sfmx_pkg::AddrW;
  localparam int unsigned CW = sfmx_pkg::CntW;

  sfmx_pkg::state_e state_q, state_d;

  logic [sfmx_pkg::TopKW-1:0]  topk_q;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic signed [15:0]          max_q, max_d;
  logic                        ovf_q, ovf_d;
  logic [sfmx_pkg::SumW-1:0]   sum_q, sum_d;
  logic [CW-1:0]               i_q, i_d;
  logic [32:0]                 t_q, t_d;
  logic [8:0]                  ip_q, ip_d;
  logic [16:0]                 hi_q, hi_d;
  logic [23:0]                 dif_q, dif_d;
  logic [27:0]                 rem_q, rem_d;
  logic [16:0]                 nlo_q, nlo_d;
  logic [16:0]                 quo_q, quo_d;
  logic [4:0]                  dcnt_q, dcnt_d;
  logic                        rkv_q, rkv_d;
  logic [AW-1:0]               rki_q, rki_d;
  logic                        have_q, have_d;
  logic [AW-1:0]               cand_i_q, cand_i_d;
  logic [16:0]                 cand_p_q, cand_p_d;
  logic [15:0]                 cand_l_q, cand_l_d;
  logic [AW-1:0]               prev_i_q, prev_i_d;
  logic [16:0]                 prev_p_q, prev_p_d;
  logic [sfmx_pkg::TopKW-1:0]  r_q, r_d;
  logic                        ov_q, ov_d;
  logic [47:0]                 od_q, od_d;
  logic                        oe_q, oe_d;
  logic                        ol_q, ol_d;

  logic                        in_acc, out_free, cfg_wr, err;
  logic                        lg_we, pb_we;
  logic [AW-1:0]               lg_waddr, pb_waddr, raddr;
  logic [15:0]                 lg_rd;
  logic [16:0]                 pb_rd, pb_wdata;
  logic [15:0]                 a_val;
  logic [4:0]                  tix;
  logic [16:0]                 lo_v, m_v, e_v;
  logic [33:0]                 num_v;
  logic [27:0]                 trial;
  logic                        elig, better;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ov_q || m_axis_tready_i;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign s_axis_tready_o = (state_q == sfmx_pkg::ST_IDLE);
  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? 32'd0 : {27'd0, topk_q};

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = oe_q;
  assign m_axis_tlast_o  = ol_q;

  assign err = ovf_q || (topk_q == '0) || (topk_q > sfmx_pkg::TopKW'(sfmx_pkg::MaxTop))
               || ({{(CW-sfmx_pkg::TopKW){1'b0}}, topk_q} > cnt_q);

  assign lg_we    = in_acc && (cnt_q < CW'(sfmx_pkg::MaxClasses));
  assign lg_waddr = cnt_q[AW-1:0];
  assign raddr    = i_q[AW-1:0];
  assign pb_waddr = i_q[AW-1:0];

  sfmx_ram #(.Width(16), .Depth(sfmx_pkg::MaxClasses)) u_logit_ram (
    .clk_i, .we_i(lg_we), .waddr_i(lg_waddr), .wdata_i(s_axis_tdata_i),
    .raddr_i(raddr), .rdata_o(lg_rd)
  );

  sfmx_ram #(.Width(17), .Depth(sfmx_pkg::MaxClasses)) u_prob_ram (
    .clk_i, .we_i(pb_we), .waddr_i(pb_waddr), .wdata_i(pb_wdata),
    .raddr_i(raddr), .rdata_o(pb_rd)
  );

  // exp datapath
  assign a_val = 16'(max_q - $signed(lg_rd));
  assign tix   = {1'b0, t_q[23:20]};
  assign lo_v  = sfmx_pkg::exp_tab(tix + 5'd1);
  assign m_v   = hi_q - 17'((25'(dif_q) + 25'd2048) >> 12);
  assign e_v   = (ip_q > 9'd16) ? 17'd0 : (m_v >> ip_q);

  // divider datapath
  assign num_v = {1'b0, pb_rd, 16'd0} + 34'(sum_q >> 1);
  assign trial = {rem_q[26:0], nlo_q[16]};

  // ranking compare
  assign elig   = (r_q == '0) || (prev_p_q > pb_rd) ||
                  ((prev_p_q == pb_rd) && (prev_i_q < rki_q));
  assign better = !have_q || (pb_rd > cand_p_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    max_d    = max_q;
    ovf_d    = ovf_q;
    sum_d    = sum_q;
    i_d      = i_q;
    t_d      = t_q;
    ip_d     = ip_q;
    hi_d     = hi_q;
    dif_d    = dif_q;
    rem_d    = rem_q;
    nlo_d    = nlo_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;
    rkv_d    = 1'b0;
    rki_d    = rki_q;
    have_d   = have_q;
    cand_i_d = cand_i_q;
    cand_p_d = cand_p_q;
    cand_l_d = cand_l_q;
    prev_i_d = prev_i_q;
    prev_p_d = prev_p_q;
    r_d      = r_q;
    ov_d     = ov_q && !m_axis_tready_i;
    od_d     = od_q;
    oe_d     = oe_q;
    ol_d     = ol_q;
    pb_we    = 1'b0;
    pb_wdata = e_v;
    unique case (state_q)
      sfmx_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (lg_we) begin
            cnt_d = cnt_q + 1'b1;
            if ($signed(s_axis_tdata_i) > max_q) begin
              max_d = $signed(s_axis_tdata_i);
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = sfmx_pkg::ST_CHECK;
          end
        end
      end
      sfmx_pkg::ST_CHECK: begin
        if (err) begin
          if (out_free) begin
            ov_d    = 1'b1;
            od_d    = '0;
            oe_d    = 1'b1;
            ol_d    = 1'b1;
            cnt_d   = '0;
            max_d   = -16'sd32768;
            ovf_d   = 1'b0;
            state_d = sfmx_pkg::ST_IDLE;
          end
        end else begin
          i_d     = '0;
          sum_d   = '0;
          state_d = sfmx_pkg::ST_EX_RD;
        end
      end
      sfmx_pkg::ST_EX_RD:  state_d = sfmx_pkg::ST_EX_MUL;
      sfmx_pkg::ST_EX_MUL: begin
        t_d     = 33'({17'd0, a_val} * {16'd0, sfmx_pkg::Log2eQ16});
        state_d = sfmx_pkg::ST_EX_INT;
      end
      sfmx_pkg::ST_EX_INT: begin
        ip_d    = t_q[32:24];
        hi_d    = sfmx_pkg::exp_tab(tix);
        dif_d   = 24'(sfmx_pkg::exp_tab(tix) - lo_v) * {12'd0, t_q[19:8]};
        state_d = sfmx_pkg::ST_EX_WR;
      end
      sfmx_pkg::ST_EX_WR: begin
        pb_we = 1'b1;
        sum_d = sum_q + {11'd0, e_v};
        i_d   = i_q + 1'b1;
        if (i_q + 1'b1 == cnt_q) begin
          i_d     = '0;
          state_d = sfmx_pkg::ST_DV_RD;
        end else begin
          state_d = sfmx_pkg::ST_EX_RD;
        end
      end
      sfmx_pkg::ST_DV_RD:  state_d = sfmx_pkg::ST_DV_LD;
      sfmx_pkg::ST_DV_LD: begin
        rem_d   = {11'd0, num_v[33:17]};
        nlo_d   = num_v[16:0];
        quo_d   = '0;
        dcnt_d  = '0;
        state_d = sfmx_pkg::ST_DV_IT;
      end
      sfmx_pkg::ST_DV_IT: begin
        nlo_d  = {nlo_q[15:0], 1'b0};
        dcnt_d = dcnt_q + 1'b1;
        if (trial >= sum_q) begin
          rem_d = trial - sum_q;
          quo_d = {quo_q[15:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[15:0], 1'b0};
        end
        if (dcnt_q == 5'd16) begin
          state_d = sfmx_pkg::ST_DV_WR;
        end
      end
      sfmx_pkg::ST_DV_WR: begin
        pb_we    = 1'b1;
        pb_wdata = quo_q;
        i_d      = i_q + 1'b1;
        if (i_q + 1'b1 == cnt_q) begin
          i_d     = '0;
          r_d     = '0;
          have_d  = 1'b0;
          state_d = sfmx_pkg::ST_RK_RUN;
        end else begin
          state_d = sfmx_pkg::ST_DV_RD;
        end
      end
      sfmx_pkg::ST_RK_RUN: begin
        if (i_q < cnt_q) begin
          rkv_d = 1'b1;
          rki_d = i_q[AW-1:0];
          i_d   = i_q + 1'b1;
        end
        if (rkv_q && elig && better) begin
          have_d   = 1'b1;
          cand_i_d = rki_q;
          cand_p_d = pb_rd;
          cand_l_d = lg_rd;
        end
        if (!(i_q < cnt_q) && !rkv_q) begin
          state_d = sfmx_pkg::ST_RK_EMT;
        end
      end
      sfmx_pkg::ST_RK_EMT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          od_d     = {1'b0, r_q[sfmx_pkg::RankW-1:0], cand_p_q, cand_l_q, cand_i_q};
          oe_d     = 1'b0;
          ol_d     = (r_q + 1'b1 == topk_q);
          prev_i_d = cand_i_q;
          prev_p_d = cand_p_q;
          r_d      = r_q + 1'b1;
          i_d      = '0;
          have_d   = 1'b0;
          if (r_q + 1'b1 == topk_q) begin
            cnt_d   = '0;
            max_d   = -16'sd32768;
            ovf_d   = 1'b0;
            state_d = sfmx_pkg::ST_IDLE;
          end else begin
            state_d = sfmx_pkg::ST_RK_RUN;
          end
        end
      end
      default: state_d = sfmx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfmx_pkg::ST_IDLE;
      topk_q  <= sfmx_pkg::TopKW'(1);
      cnt_q   <= '0;
      max_q   <= -16'sd32768;
      ovf_q   <= 1'b0;
      sum_q   <= '0;
      i_q     <= '0;
      dcnt_q  <= '0;
      rkv_q   <= 1'b0;
      have_q  <= 1'b0;
      r_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && !paddr_i[2]) begin
        topk_q <= pwdata_i[sfmx_pkg::TopKW-1:0];
      end
      cnt_q   <= cnt_d;
      max_q   <= max_d;
      ovf_q   <= ovf_d;
      sum_q   <= sum_d;
      i_q     <= i_d;
      dcnt_q  <= dcnt_d;
      rkv_q   <= rkv_d;
      have_q  <= have_d;
      r_q     <= r_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    ip_q     <= ip_d;
    hi_q     <= hi_d;
    dif_q    <= dif_d;
    rem_q    <= rem_d;
    nlo_q    <= nlo_d;
    quo_q    <= quo_d;
    rki_q    <= rki_d;
    cand_i_q <= cand_i_d;
    cand_p_q <= cand_p_d;
    cand_l_q <= cand_l_d;
    prev_i_q <= prev_i_d;
    prev_p_q <= prev_p_d;
    od_q     <= od_d;
    oe_q     <= oe_d;
    ol_q     <= ol_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(sfmx_pkg::MaxClasses))
    else $error("class count beyond store depth");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oe_q) |-> ol_q)
    else $error("error transaction without last");

  a_err_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfmx_pkg::ST_CHECK && err && out_free) |=> (cnt_q == '0 && !ovf_q))
    else $error("sample state not cleared after error");

  a_sum_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfmx_pkg::ST_DV_IT) |-> (sum_q >= sfmx_pkg::SumW'(65536)))
    else $error("exp sum below one during division");

endmodule

### tb/softmax_top_k_select_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// softmax_top_k_select_chk
// watches the logit and result streams and the register port, predicts the
// ranked softmax results of each sample and compares them field by field
// ----------------------------------------------------------------------------
module softmax_top_k_select_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,  // logit
  input  logic        s_axis_tlast_i,  // last
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,  // class index, logit_out, probability, rank
  input  logic        m_axis_tuser_i,  // error
  input  logic        m_axis_tlast_i,  // last_out
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          got_cnt_o,
  output int          err_cnt_o
);

  typedef struct packed {
    logic [9:0]  cls;
    logic [15:0] lgt;
    logic [16:0] prob;
    logic [3:0]  rank;
    logic        err;
    logic        lst;
  } ranked_t;

  ranked_t          ranked_q[$];
  logic signed [15:0] logit_buf[sfmx_pkg::MaxClasses];
  logic [31:0]      probs[sfmx_pkg::MaxClasses];
  int unsigned      n_cls;
  logic signed [15:0] peak;
  logic             ovf;
  logic [4:0]       k_reg;

  function automatic logic [31:0] exp_fix(input logic [15:0] a);
    logic [63:0] t;
    logic [31:0] f, idx, rem, hi, lo, m;
    logic [31:0] tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
      48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    t = 64'(a) * 64'd94548;
    if ((t >> 24) > 16) return 0;
    f = t[23:0];
    idx = f >> 20;
    rem = (f >> 8) & 32'hfff;
    hi = tab[idx];
    lo = tab[idx + 1];
    m = hi - (((hi - lo) * rem + 2048) >> 12);
    return m >> (t >> 24);
  endfunction

  function automatic bit beats(input int unsigned i, input int unsigned j);
    if (probs[i] != probs[j]) return probs[i] > probs[j];
    return i < j;
  endfunction

  task automatic rank_sample();
    logic [31:0] total;
    logic [63:0] num;
    int unsigned prev, cand;
    bit have;
    ranked_t r;
    prev = 0;
    if (ovf || k_reg == 0 || k_reg > sfmx_pkg::MaxTop || k_reg > n_cls) begin
      r = '0;
      r.err = 1'b1;
      r.lst = 1'b1;
      ranked_q = {ranked_q, r};
    end else begin
      total = 0;
      for (int i = 0; i < n_cls; i++) begin
        probs[i] = exp_fix(16'(peak - logit_buf[i]));
        total += probs[i];
      end
      for (int i = 0; i < n_cls; i++) begin
        num = (64'(probs[i]) << 16) + 64'(total >> 1);
        probs[i] = 32'(num / total);
      end
      for (int rk = 0; rk < k_reg; rk++) begin
        have = 0;
        cand = 0;
        for (int i = 0; i < n_cls; i++) begin
          if (rk > 0 && !beats(prev, i)) continue;
          if (!have || beats(i, cand)) begin
            cand = i;
            have = 1;
          end
        end
        prev = cand;
        r.cls = cand[9:0];
        r.lgt = logit_buf[cand];
        r.prob = probs[cand][16:0];
        r.rank = rk[3:0];
        r.err = 1'b0;
        r.lst = (rk + 1 == k_reg);
        ranked_q = {ranked_q, r};
      end
    end
    n_cls = 0;
    peak = -16'sd32768;
    ovf = 0;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("mismatch %s: got %0h expected %0h", what, got, exp_v);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ranked_t e, g;
    if (!rst_ni) begin
      ranked_q.delete();
      n_cls = 0;
      peak = -16'sd32768;
      ovf = 0;
      k_reg = 5'd1;
      fail_cnt_o = 0;
      got_cnt_o = 0;
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        g = {m_axis_tdata_i[9:0],
             m_axis_tdata_i[25:10], m_axis_tdata_i[42:26], m_axis_tdata_i[46:43],
             m_axis_tuser_i, m_axis_tlast_i};
        got_cnt_o++;
        if (m_axis_tuser_i) err_cnt_o++;
        if (ranked_q.size() == 0) begin
          report("unexpected transaction", 32'd1, 32'd0);
        end else begin
          e = ranked_q.pop_front();
          if (g.cls != e.cls) report("class index", g.cls, e.cls);
          if (g.lgt != e.lgt) report("logit", g.lgt, e.lgt);
          if (g.prob != e.prob) report("probability", g.prob, e.prob);
          if (g.rank != e.rank) report("rank", g.rank, e.rank);
          if (g.err != e.err) report("error", g.err, e.err);
          if (g.lst != e.lst) report("last", g.lst, e.lst);
        end
      end
      if (psel_i && penable_i && pwrite_i && paddr_i == 3'd0) k_reg = pwdata_i[4:0];
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (n_cls < sfmx_pkg::MaxClasses) begin
          logit_buf[n_cls] = s_axis_tdata_i;
          n_cls++;
          if ($signed(s_axis_tdata_i) > peak) peak = s_axis_tdata_i;
        end else begin
          ovf = 1;
        end
        if (s_axis_tlast_i) rank_sample();
      end
      pending_o = ranked_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives samples of logits and top_k settings into the softmax top-k block
// with random bursts and stalls; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb;

  logic        clk_i, rst_ni;
  logic        s_valid, s_ready, s_last, m_valid, m_user, m_last;
  logic        m_ready = 1'b1;
  logic [15:0] s_data;
  logic [47:0] m_data;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_cnt, pending, got_cnt, err_cnt;
  int          cycles = 0;
  int          items;
  bit          stall_mode;

  softmax_top_k_select_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  softmax_top_k_select_chk u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data), .m_axis_tuser_i(m_user), .m_axis_tlast_i(m_last),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_cnt_o(fail_cnt), .pending_o(pending),
    .got_cnt_o(got_cnt), .err_cnt_o(err_cnt)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stall pattern, with stall-free stretches
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 1);
    m_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    if (cycles > 3000000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic push_logit(input logic [15:0] v, input logic lst);
    int gap;
    if ($urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      s_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1; s_data <= v; s_last <= lst;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items++;
  endtask

  task automatic send_sample(input int n, input int span);
    int base;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < n; i++)
      push_logit(span == 0 ? 16'($urandom) :
                 16'(base + $urandom_range(0, span)), i == n - 1);
    s_valid <= 0;
  endtask

  initial begin
    items = 0;
    s_valid = 0; s_data = 0; s_last = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, ties, single class, k too big, k of zero
    push_logit(16'h7fff, 0); push_logit(16'h8000, 0); push_logit(16'h0000, 1);
    s_valid <= 0;
    wait_drained();
    push_logit(16'h8000, 1); s_valid <= 0;
    wait_drained();
    reg_write(3'd0, 32'd3);
    push_logit(16'h0100, 0); push_logit(16'h0100, 0); push_logit(16'h0100, 0);
    push_logit(16'hffff, 1); s_valid <= 0;
    wait_drained();
    push_logit(16'h1234, 0); push_logit(16'h5555, 1); s_valid <= 0;
    wait_drained();
    reg_write(3'd0, 32'd0);
    send_sample(3, 0);
    wait_drained();
    reg_write(3'd0, 32'd16);
    send_sample(16, 0);
    wait_drained();
    reg_write(3'd0, 32'd17);
    send_sample(20, 0);
    wait_drained();
    reg_write(3'd4, 32'd5);
    reg_write(3'd0, 32'd31);
    send_sample(2, 0);
    wait_drained();
    // random samples, mostly well formed
    while (items < 380) begin
      reg_write(3'd0, $urandom_range(0, 10) == 0 ? $urandom_range(0, 31) :
                $urandom_range(1, 16));
      for (int s = 0; s < 4; s++)
        send_sample($urandom_range(1, 24),
                    $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 2048));
      wait_drained();
    end
    $display("covered %0d logits, %0d results, %0d error results",
             items, got_cnt, err_cnt);
    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/sfmx_pkg.sv
sv/sfmx_ram.sv
sv/softmax_top_k_select_top.sv
tb/softmax_top_k_select_chk.sv
tb/tb.sv
